// File: rtl/core/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg: shared types and constants
// Payload structs, register indexes and trim constants for the compensation.
// ----------------------------------------------------------------------------
package bsc_pkg;

	typedef struct packed {
		logic [19:0] raw_temperature;
		logic [19:0] pressure_adc;
	} bsc_in_t;

	typedef struct packed {
		logic signed [31:0] temperature_centi;
		logic [31:0] pressure_pa;
		logic divide_fault;
	} bsc_out_t;

	typedef struct packed {
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
		logic [15:0] p1;
		logic [15:0] p2;
		logic [15:0] p3;
		logic [15:0] p4;
		logic [15:0] p5;
		logic [15:0] p6;
		logic [15:0] p7;
		logic [15:0] p8;
		logic [15:0] p9;
	} bsc_trim_t;

	localparam int NUM_REGS = 6;
	localparam logic [2:0] REG_T1_T2 = 3'd0;
	localparam logic [2:0] REG_T3_P1 = 3'd1;
	localparam logic [2:0] REG_P2_P3 = 3'd2;
	localparam logic [2:0] REG_P4_P5 = 3'd3;
	localparam logic [2:0] REG_P6_P7 = 3'd4;
	localparam logic [2:0] REG_P8_P9 = 3'd5;

	localparam logic [31:0] FINE_OFFSET = 32'd64000;
	localparam logic [31:0] UNITY_Q15 = 32'd32768;
	localparam logic [31:0] FULL_SCALE = 32'd1048576;
	localparam logic [31:0] SCALE_3125 = 32'd3125;
	localparam logic [31:0] ROUND_HALF = 32'd128;

	// Low 32 bits of a product.
	function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] p;
		p = a * b;
		return p[31:0];
	endfunction

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

endpackage

// File: rtl/core/bsc_div.sv
// ----------------------------------------------------------------------------
// bsc_div: pipelined unsigned divider
// Restoring division, one quotient bit per stage, 32 stages, with a tag
// that travels alongside.
// ----------------------------------------------------------------------------
module bsc_div #(
	parameter int TAG_W = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	input  logic [TAG_W-1:0] in_tag,
	output logic out_valid,
	output logic [31:0] quotient,
	output logic [TAG_W-1:0] out_tag
);
	localparam int N = 32;

	logic [N:0] v_s;
	logic [31:0] rem_s [N+1];
	logic [31:0] num_s [N+1];
	logic [31:0] den_s [N+1];
	logic [TAG_W-1:0] tag_s [N+1];

	// Stage zero takes the operands.
	assign v_s[0] = in_valid;
	assign rem_s[0] = '0;
	assign num_s[0] = dividend;
	assign den_s[0] = divisor;
	assign tag_s[0] = in_tag;

	// One shift-subtract step per stage; num shifts out dividend bits and
	// collects quotient bits at the bottom.
	for (genvar k = 0; k < N; k++) begin : g_step
		logic [32:0] trial;
		logic [32:0] diff;
		assign trial = {rem_s[k], num_s[k][31]};
		assign diff = trial - {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (!diff[32]) begin
				rem_s[k+1] <= diff[31:0];
			end else begin
				rem_s[k+1] <= trial[31:0];
			end
			num_s[k+1] <= {num_s[k][30:0], ~diff[32]};
			den_s[k+1] <= den_s[k];
			tag_s[k+1] <= tag_s[k];
		end
	end

	assign out_valid = v_s[N];
	assign quotient = num_s[N];
	assign out_tag = tag_s[N];
endmodule

// File: rtl/core/bsc_front.sv
// ----------------------------------------------------------------------------
// bsc_front: fine temperature and pressure divisor/dividend pipeline
// Eight register stages from raw readings to the divider operands and the
// finished temperature.
// ----------------------------------------------------------------------------
module bsc_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  bsc_pkg::bsc_in_t in_item,
	input  bsc_pkg::bsc_trim_t trim,
	output logic out_valid,
	output logic [31:0] temp_out,
	output logic [31:0] dividend_out,
	output logic [31:0] divisor_out,
	output logic big_out
);
	import bsc_pkg::*;

	function automatic logic [31:0] asr(input logic [31:0] x, input int n);
		return 32'($signed(x) >>> n);
	endfunction

	logic [7:0] v_q;

	// Stage 1: temperature differences.
	logic [31:0] ta_s1, td_s1;
	logic [19:0] adcp_s1;
	// Stage 2: products.
	logic [31:0] a_s2, dd_s2;
	logic [19:0] adcp_s2;
	// Stage 3: second temperature product.
	logic [31:0] a_s3, b_s3;
	logic [19:0] adcp_s3;
	// Stage 4: fine temperature.
	logic [31:0] tf_s4;
	logic [19:0] adcp_s4;
	// Stage 5: v1, square, temp product.
	logic [31:0] v1_s5, sq_s5, t5_s5;
	logic [19:0] adcp_s5;
	// Stage 6: pressure products.
	logic [31:0] m6_s6, m5_s6, m3_s6, m2_s6, temp_s6;
	logic [19:0] adcp_s6;
	// Stage 7: partial v2 and v1 sum.
	logic [31:0] v2_s7, v1b_s7, temp_s7;
	logic [19:0] adcp_s7;
	// Stage 8: divisor product and dividend base.
	logic [31:0] div_s8, num_s8, temp_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[6:0], in_valid};
		end
	end

	logic [31:0] adc_t, t1;
	assign adc_t = {12'd0, in_item.raw_temperature};
	assign t1 = {16'd0, trim.t1};

	always_ff @(posedge clk) begin
		ta_s1 <= asr(adc_t, 3) - {t1[30:0], 1'b0};
		td_s1 <= asr(adc_t, 4) - t1;
		adcp_s1 <= in_item.pressure_adc;

		a_s2 <= asr(mul32(ta_s1, sx16(trim.t2)), 11);
		dd_s2 <= asr(mul32(td_s1, td_s1), 12);
		adcp_s2 <= adcp_s1;

		a_s3 <= a_s2;
		b_s3 <= asr(mul32(dd_s2, sx16(trim.t3)), 14);
		adcp_s3 <= adcp_s2;

		tf_s4 <= a_s3 + b_s3;
		adcp_s4 <= adcp_s3;

		v1_s5 <= asr(tf_s4, 1) - FINE_OFFSET;
		sq_s5 <= mul32(asr(asr(tf_s4, 1) - FINE_OFFSET, 2),
			asr(asr(tf_s4, 1) - FINE_OFFSET, 2));
		t5_s5 <= mul32(tf_s4, 32'd5) + ROUND_HALF;
		adcp_s5 <= adcp_s4;

		m6_s6 <= mul32(asr(sq_s5, 11), sx16(trim.p6));
		m5_s6 <= mul32(v1_s5, sx16(trim.p5));
		m3_s6 <= mul32(sx16(trim.p3), asr(sq_s5, 13));
		m2_s6 <= mul32(sx16(trim.p2), v1_s5);
		temp_s6 <= asr(t5_s5, 8);
		adcp_s6 <= adcp_s5;

		v2_s7 <= asr(m6_s6 + {m5_s6[30:0], 1'b0}, 2) + {trim.p4, 16'd0};
		v1b_s7 <= asr(asr(m3_s6, 3) + asr(m2_s6, 1), 18);
		temp_s7 <= temp_s6;
		adcp_s7 <= adcp_s6;

		div_s8 <= asr(mul32(UNITY_Q15 + v1b_s7, {16'd0, trim.p1}), 15);
		num_s8 <= mul32((FULL_SCALE - {12'd0, adcp_s7}) - asr(v2_s7, 12), SCALE_3125);
		temp_s8 <= temp_s7;
	end

	assign out_valid = v_q[7];
	assign temp_out = temp_s8;
	assign divisor_out = div_s8;
	assign big_out = num_s8[31];
	assign dividend_out = num_s8[31] ? num_s8 : {num_s8[30:0], 1'b0};
endmodule

// File: rtl/core/bsc_back.sv
// ----------------------------------------------------------------------------
// bsc_back: pressure correction after the divide
// Three register stages of second-order correction on the quotient.
// ----------------------------------------------------------------------------
module bsc_back (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [31:0] quot,
	input  logic big,
	input  logic fault,
	input  logic [31:0] temp,
	input  logic [15:0] p7,
	input  logic [15:0] p8,
	input  logic [15:0] p9,
	output logic out_valid,
	output bsc_pkg::bsc_out_t out_item
);
	import bsc_pkg::*;

	function automatic logic [31:0] asr(input logic [31:0] x, input int n);
		return 32'($signed(x) >>> n);
	endfunction

	logic [2:0] v_q;
	logic [31:0] p_s1, q_s1, t_s1, p_s2, a_s2, b_s2, t_s2, p_s3, t_s3;
	logic f_s1, f_s2, f_s3;
	logic [31:0] pq;

	assign pq = big ? {quot[30:0], 1'b0} : quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[1:0], in_valid};
		end
	end

	// Square of the scaled quotient, then the two trim products, then the sum.
	always_ff @(posedge clk) begin
		p_s1 <= pq;
		q_s1 <= mul32(pq >> 3, pq >> 3) >> 13;
		t_s1 <= temp;
		f_s1 <= fault;

		p_s2 <= p_s1;
		a_s2 <= asr(mul32(sx16(p9), q_s1), 12);
		b_s2 <= asr(mul32(p_s1 >> 2, sx16(p8)), 13);
		t_s2 <= t_s1;
		f_s2 <= f_s1;

		p_s3 <= f_s2 ? '0 : p_s2 + asr(a_s2 + b_s2 + sx16(p7), 4);
		t_s3 <= t_s2;
		f_s3 <= f_s2;
	end

	assign out_valid = v_q[2];
	assign out_item.temperature_centi = t_s3;
	assign out_item.pressure_pa = p_s3;
	assign out_item.divide_fault = f_s3;
endmodule

// File: rtl/core/baro_sensor_compensation.sv
// ----------------------------------------------------------------------------
// baro_sensor_compensation: 32-bit integer pressure/temperature compensation
// From start to done: 8 front stages, 32 divider stages and
// 3 correction stages. Throughput one reading per cycle; busy is never high.
// The receiver cannot stall: done pulses once per result. Reset clears the
// trim registers to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module baro_sensor_compensation (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  bsc_pkg::bsc_in_t in_item,
	output logic done,
	output bsc_pkg::bsc_out_t result,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data
);
	import bsc_pkg::*;

	logic [31:0] regs_q [NUM_REGS];
	bsc_trim_t trim;
	logic fv, dv, bv;
	logic [31:0] ftemp, fdvd, fdvs, quot;
	logic fbig;
	logic [33:0] tag_in, tag_out;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	// Trim register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) regs_q[i] <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_T1_T2: regs_q[REG_T1_T2] <= cfg_data;
				REG_T3_P1: regs_q[REG_T3_P1] <= cfg_data;
				REG_P2_P3: regs_q[REG_P2_P3] <= cfg_data;
				REG_P4_P5: regs_q[REG_P4_P5] <= cfg_data;
				REG_P6_P7: regs_q[REG_P6_P7] <= cfg_data;
				REG_P8_P9: regs_q[REG_P8_P9] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign trim.t1 = regs_q[REG_T1_T2][15:0];
	assign trim.t2 = regs_q[REG_T1_T2][31:16];
	assign trim.t3 = regs_q[REG_T3_P1][15:0];
	assign trim.p1 = regs_q[REG_T3_P1][31:16];
	assign trim.p2 = regs_q[REG_P2_P3][15:0];
	assign trim.p3 = regs_q[REG_P2_P3][31:16];
	assign trim.p4 = regs_q[REG_P4_P5][15:0];
	assign trim.p5 = regs_q[REG_P4_P5][31:16];
	assign trim.p6 = regs_q[REG_P6_P7][15:0];
	assign trim.p7 = regs_q[REG_P6_P7][31:16];
	assign trim.p8 = regs_q[REG_P8_P9][15:0];
	assign trim.p9 = regs_q[REG_P8_P9][31:16];

	bsc_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(start && !busy), .in_item(in_item),
		.trim(trim), .out_valid(fv), .temp_out(ftemp), .dividend_out(fdvd),
		.divisor_out(fdvs), .big_out(fbig)
	);

	// Tag carries temperature, the large-dividend flag and the fault flag.
	assign tag_in = {ftemp, fbig, fdvs == '0};

	bsc_div #(.TAG_W(34)) u_div (
		.clk(clk), .arst_n(arst_n), .in_valid(fv), .dividend(fdvd), .divisor(fdvs),
		.in_tag(tag_in), .out_valid(dv), .quotient(quot), .out_tag(tag_out)
	);

	bsc_back u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(dv), .quot(quot), .big(tag_out[1]),
		.fault(tag_out[0]), .temp(tag_out[33:2]), .p7(trim.p7), .p8(trim.p8),
		.p9(trim.p9), .out_valid(bv), .out_item(result)
	);

	assign done = bv;

	// A fault result always reports zero pressure.
	assert property (@(posedge clk) disable iff (!arst_n)
		done && result.divide_fault |-> result.pressure_pa == '0)
		else $error("fault result with nonzero pressure");

	// Every divider output appears as a result after the correction stages.
	assert property (@(posedge clk) disable iff (!arst_n) dv |-> ##3 done)
		else $error("result lost after divider");

	// Every front valid reaches the divider exit.
	assert property (@(posedge clk) disable iff (!arst_n) fv |-> ##32 dv)
		else $error("divider dropped an item");
endmodule

// File: tb/tb_baro_sensor_compensation.sv
// ----------------------------------------------------------------------------
// tb_baro_sensor_compensation: self-checking bench for the compensation block
// Drives directed and random raw readings under several trim settings and
// compares each result against typed-in values or a behavioral model of the 32-bit scheme.
// ----------------------------------------------------------------------------
module tb_baro_sensor_compensation;
	timeunit 1ns;
	timeprecision 1ps;

	import bsc_pkg::*;

	localparam int DRAIN_CYCLES = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	bsc_in_t in_item = '0;
	logic done;
	bsc_out_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	logic [31:0] trim_regs [NUM_REGS];
	bsc_out_t comp_expected [$];
	int error_count = 0;
	bit idle_enable = 1'b1;

	// Directed readings; expected values typed in only where trims are zero.
	typedef struct {
		logic [19:0] raw_t;
		logic [19:0] raw_p;
		bit known;
		bsc_out_t want;
	} reading_row_t;

	baro_sensor_compensation DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_item(in_item),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Arithmetic shift right of a 32-bit word.
	function automatic logic [31:0] sar(input logic [31:0] x, input int n);
		return 32'($signed(x) >>> n);
	endfunction

	function automatic logic [31:0] prod(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] w;
		w = a * b;
		return w[31:0];
	endfunction

	function automatic logic [31:0] ext16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	// Compensate one pair of readings with the current trim words.
	function automatic bsc_out_t compensate(input logic [19:0] raw_t, input logic [19:0] raw_p);
		logic [31:0] adc_t, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic [31:0] a, d, tf, v1, v2, sq, p, q;
		bsc_out_t r;
		adc_t = {12'd0, raw_t};
		t1 = {16'd0, trim_regs[REG_T1_T2][15:0]};
		t2 = ext16(trim_regs[REG_T1_T2][31:16]);
		t3 = ext16(trim_regs[REG_T3_P1][15:0]);
		p1 = {16'd0, trim_regs[REG_T3_P1][31:16]};
		p2 = ext16(trim_regs[REG_P2_P3][15:0]);
		p3 = ext16(trim_regs[REG_P2_P3][31:16]);
		p4 = ext16(trim_regs[REG_P4_P5][15:0]);
		p5 = ext16(trim_regs[REG_P4_P5][31:16]);
		p6 = ext16(trim_regs[REG_P6_P7][15:0]);
		p7 = ext16(trim_regs[REG_P6_P7][31:16]);
		p8 = ext16(trim_regs[REG_P8_P9][15:0]);
		p9 = ext16(trim_regs[REG_P8_P9][31:16]);
		// Fine temperature.
		a = sar(prod((adc_t >> 3) - (t1 << 1), t2), 11);
		d = (adc_t >> 4) - t1;
		tf = a + sar(prod(sar(prod(d, d), 12), t3), 14);
		r.temperature_centi = sar(prod(tf, 32'd5) + 32'd128, 8);
		// Pressure divisor.
		v1 = sar(tf, 1) - 32'd64000;
		sq = prod(sar(v1, 2), sar(v1, 2));
		v2 = prod(sar(sq, 11), p6) + (prod(v1, p5) << 1);
		v2 = sar(v2, 2) + (p4 << 16);
		v1 = sar(sar(prod(p3, sar(sq, 13)), 3) + sar(prod(p2, v1), 1), 18);
		v1 = sar(prod(32'd32768 + v1, p1), 15);
		r.divide_fault = (v1 == 0);
		if (v1 == 0) begin
			p = '0;
		end else begin
			p = prod((32'd1048576 - {12'd0, raw_p}) - sar(v2, 12), 32'd3125);
			if (p < 32'h8000_0000)
				p = (p << 1) / v1;
			else
				p = (p / v1) << 1;
			q = prod(p >> 3, p >> 3) >> 13;
			v1 = sar(prod(p9, q), 12);
			v2 = sar(prod(p >> 2, p8), 13);
			p = p + sar(v1 + v2 + p7, 4);
		end
		r.pressure_pa = p;
		return r;
	endfunction

	task automatic write_trim(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx < NUM_REGS)
			trim_regs[idx] = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Bring the pipeline to rest before touching the trims.
	task automatic settle();
		while (comp_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_trims(input logic [31:0] w [NUM_REGS]);
		settle();
		write_trim(REG_T1_T2, w[0]);
		write_trim(REG_T3_P1, w[1]);
		write_trim(REG_P2_P3, w[2]);
		write_trim(REG_P4_P5, w[3]);
		write_trim(REG_P6_P7, w[4]);
		write_trim(REG_P8_P9, w[5]);
	endtask

	// Offer one reading; start stays high across back-to-back transactions.
	task automatic send_reading(input logic [19:0] raw_t, input logic [19:0] raw_p,
			input bit known, input bsc_out_t want);
		int gap;
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		in_item <= '{raw_temperature: raw_t, pressure_adc: raw_p};
		do @(posedge clk); while (busy);
		comp_expected.push_back(known ? want : compensate(raw_t, raw_p));
		@(negedge clk);
	endtask

	task automatic stop_sending();
		start <= 1'b0;
	endtask

	function automatic logic [19:0] rand_raw();
		case ($urandom_range(0, 5))
			0: return 20'h00000;
			1: return 20'hFFFFF;
			2: return 20'($urandom_range(400000, 600000));
			default: return 20'($urandom);
		endcase
	endfunction

	// Trim words: zero, all ones, mixed signs, and random.
	function automatic logic [31:0] rand_trim_word(input int mode);
		case (mode)
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h7FFF_8000;
			default: return $urandom;
		endcase
	endfunction

	// Result checker.
	always @(posedge clk) begin
		bsc_out_t want;
		if (arst_n && done) begin
			if (comp_expected.size() == 0) begin
				$error("result with nothing expected: %h", result);
				error_count++;
			end else begin
				want = comp_expected.pop_front();
				if (result.temperature_centi !== want.temperature_centi) begin
					$error("temperature_centi: expected %0d, got %0d",
						want.temperature_centi, result.temperature_centi);
					error_count++;
				end
				if (result.pressure_pa !== want.pressure_pa) begin
					$error("pressure_pa: expected %0d, got %0d", want.pressure_pa,
						result.pressure_pa);
					error_count++;
				end
				if (result.divide_fault !== want.divide_fault) begin
					$error("divide_fault: expected %0b, got %0b", want.divide_fault,
						result.divide_fault);
					error_count++;
				end
			end
		end
	end

	// Watchdog.
	initial begin
		#5ms;
		$display("baro_sensor_compensation: mismatch");
		$finish;
	end

	initial begin
		reading_row_t rows [$];
		logic [31:0] w [NUM_REGS];
		logic [31:0] typical [NUM_REGS];
		bsc_out_t zero_fault;
		for (int i = 0; i < NUM_REGS; i++)
			trim_regs[i] = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// With all trims zero: fine temp 0, temperature 0, divisor 0 -> fault.
		zero_fault = '{temperature_centi: 0, pressure_pa: 0, divide_fault: 1'b1};
		rows.push_back('{20'h00000, 20'h00000, 1, zero_fault});
		rows.push_back('{20'hFFFFF, 20'hFFFFF, 1, zero_fault});
		rows.push_back('{20'hAAAAA, 20'h55555, 1, zero_fault});
		foreach (rows[i])
			send_reading(rows[i].raw_t, rows[i].raw_p, rows[i].known, rows[i].want);
		stop_sending();

		// Sensor-like trims, then readings across the field extremes.
		typical = '{32'h6A0D_6E4B, 32'h8E5B_0032, 32'h0BB8_D5D4, 32'hFF3F_1C3A,
			32'h3E6F_FFF9, 32'h1770_C0F4};
		load_trims(typical);
		write_trim(3'd6, 32'hDEAD_BEEF);
		write_trim(3'd7, 32'h1234_5678);
		rows.delete();
		rows.push_back('{20'h00000, 20'h00000, 0, '0});
		rows.push_back('{20'hFFFFF, 20'hFFFFF, 0, '0});
		rows.push_back('{20'h00000, 20'hFFFFF, 0, '0});
		rows.push_back('{20'hFFFFF, 20'h00000, 0, '0});
		rows.push_back('{20'h7E6F0, 20'h655A0, 0, '0});
		rows.push_back('{20'h55555, 20'hAAAAA, 0, '0});
		rows.push_back('{20'h80000, 20'h80000, 0, '0});
		rows.push_back('{20'h7FFFF, 20'h7FFFF, 0, '0});
		rows.push_back('{20'h00001, 20'h00001, 0, '0});
		foreach (rows[i])
			send_reading(rows[i].raw_t, rows[i].raw_p, 0, '0);
		stop_sending();

		// Extreme trims: all ones, large dividend path and mixed signs.
		w = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF};
		load_trims(w);
		for (int i = 0; i < 6; i++)
			send_reading(rand_raw(), rand_raw(), 0, '0);
		stop_sending();
		w = '{32'h7FFF_0000, 32'h0001_7FFF, 32'h8000_7FFF, 32'h7FFF_8000,
			32'h8000_8000, 32'h7FFF_7FFF};
		load_trims(w);
		for (int i = 0; i < 6; i++)
			send_reading(rand_raw(), rand_raw(), 0, '0);
		stop_sending();

		// Random phases over several trim settings.
		for (int ph = 0; ph < 10; ph++) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				if (ph < 4)
					w[i] = typical[i] ^ (32'($urandom) & 32'h00FF_00FF);
				else
					w[i] = rand_trim_word($urandom_range(0, 5));
			end
			if (ph == 8)
				w[1][31:16] = 16'd0;
			load_trims(w);
			if (ph == 9)
				idle_enable = 1'b0;
			for (int i = 0; i < 120; i++) begin
				send_reading(rand_raw(), rand_raw(), 0, '0);
				// Once, midway through phase 2, hold off until the pipeline has emptied.
				if (ph == 2 && i == 60) begin
					stop_sending();
					while (comp_expected.size() != 0)
						@(posedge clk);
					@(negedge clk);
				end
			end
			stop_sending();
		end

		settle();
		if (error_count == 0 && comp_expected.size() == 0)
			$display("baro_sensor_compensation: match");
		else
			$display("baro_sensor_compensation: mismatch");
		$finish;
	end

endmodule
